// ===== rtl/conv2d_nhwc_clamped_unit_defines.svh =====
// assertion macros shared by the convolution unit rtl
`ifndef CONV2D_NHWC_CLAMPED_UNIT_DEFINES_SVH
`define CONV2D_NHWC_CLAMPED_UNIT_DEFINES_SVH

// same-cycle implication, checked on every clk edge outside reset
`define CNC_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every clk edge outside reset
`define CNC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cnc_pkg.sv =====
// shared types, constants and helpers for the convolution unit
package cnc_pkg;

    // field widths of the command and result beats
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned ADDR_W    = 14;
    localparam int unsigned DATA_W    = 16;
    localparam int unsigned PIX_W     = 5;
    localparam int unsigned ACC_W     = 48;
    localparam int unsigned CH_W      = 4;
    localparam int unsigned CFG_IDX_W = 3;

    // words reachable by a load address
    localparam int unsigned STORE_SPAN = 1 << ADDR_W;

    // output channel count is limited by the channel tag
    localparam int unsigned CH_CAP = 1 << CH_W;

    // internal index widths, bounded by the register field widths
    localparam int unsigned Y_W  = 10;  // window row / column, signed
    localparam int unsigned MI_W = 22;  // running map index, signed
    localparam int unsigned WI_W = 15;  // running weight index

    // defaults for the top level parameters
    localparam int unsigned DEF_MAX_WIDTH  = 32;
    localparam int unsigned DEF_MAX_HEIGHT = 32;
    localparam int unsigned DEF_MAX_CH_IN  = 16;
    localparam int unsigned DEF_MAX_CH_OUT = 16;
    localparam int unsigned DEF_KERNEL     = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_MAP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_WGT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_IN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_OUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_PAD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_LOW      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_HIGH     = 3'd7;

    // one tap issued by the sequencer toward the datapath
    typedef struct packed {
        logic              valid;
        logic              ok;        // tap inside the map and the stores
        logic              tap_last;  // final tap of the output channel
        logic [CH_W-1:0]   ch;
        logic              ch_last;   // final output channel of the pixel
        logic [ADDR_W-1:0] map_addr;
        logic [ADDR_W-1:0] wgt_addr;
    } issue_t;

    // store write from a load beat
    typedef struct packed {
        logic                     map_we;
        logic                     wgt_we;
        logic [ADDR_W-1:0]        addr;
        logic signed [DATA_W-1:0] data;
    } load_t;

    // datapath status back to the sequencer
    typedef struct packed {
        logic adv;   // pipeline moves this cycle
        logic busy;  // taps still in flight before the accumulator
    } status_t;

    // size register clipped into 1..maxv
    function automatic logic [5:0] sat_dim(input logic [5:0] v, input int unsigned maxv);
        if (v == 6'd0) begin
            return 6'd1;
        end
        if (32'(v) > maxv) begin
            return 6'(maxv);
        end
        return v;
    endfunction

endpackage

// ===== rtl/cnc_if.sv =====
// command and result channel interfaces of the convolution unit
interface cnc_cmd_if import cnc_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [ADDR_W-1:0]        store_addr;
    logic signed [DATA_W-1:0] load_value;
    logic [PIX_W-1:0]         pixel_row;
    logic [PIX_W-1:0]         pixel_col;

    modport source (
        output valid, command, store_addr, load_value, pixel_row, pixel_col,
        input  ready
    );
    modport sink (
        input  valid, command, store_addr, load_value, pixel_row, pixel_col,
        output ready
    );
endinterface

interface cnc_res_if import cnc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] out_value;
    logic [CH_W-1:0]         out_channel;
    logic                    last;

    modport source (
        output valid, out_value, out_channel, last,
        input  ready
    );
    modport sink (
        input  valid, out_value, out_channel, last,
        output ready
    );
endinterface

// ===== rtl/conv2d_nhwc_clamped_unit.sv =====
// top level: one output pixel of an nhwc convolution with clamped results
//
//  channel  dir  beat contents
//  cmd      in   command, store_addr, load_value, pixel_row, pixel_col
//  res      out  out_value, out_channel, last
//  cfg_*    in   write enable, register index, write data (no handshake)
//
// a load beat writes its store directly; the block stays ready for the next beat
// a compute beat runs the setup states ST_SETUP1, ST_SETUP2 and ST_SETUP3, then one tap per
// cycle from the single shared multiply-accumulate while no result beat stalls:
// channels_out * KERNEL^2 * channels_in taps, then drains the multiply pipe in ST_DRAIN
// a stalled result beat freezes the tap pipe; the next beat is accepted while
// the last results of a pixel still wait in the result register
// the stores have no reset and no clearing pass; the user must see that only written words are read
`include "conv2d_nhwc_clamped_unit_defines.svh"

module conv2d_nhwc_clamped_unit import cnc_pkg::*; #(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int unsigned MAX_CH_IN  = DEF_MAX_CH_IN,
    parameter int unsigned MAX_CH_OUT = DEF_MAX_CH_OUT,
    parameter int unsigned KERNEL     = DEF_KERNEL
) (
    input  logic                 clk,
    input  logic                 rst_n,
    cnc_cmd_if.sink              cmd,
    cnc_res_if.source            res,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ACC_W-1:0]     cfg_data
);

    localparam int unsigned MAP_FULL  = MAX_WIDTH * MAX_HEIGHT * MAX_CH_IN;
    localparam int unsigned WGT_FULL  = MAX_CH_OUT * KERNEL * KERNEL * MAX_CH_IN;
    localparam int unsigned MAP_DEPTH = (MAP_FULL < STORE_SPAN) ? MAP_FULL : STORE_SPAN;
    localparam int unsigned WGT_DEPTH = (WGT_FULL < STORE_SPAN) ? WGT_FULL : STORE_SPAN;
    localparam int unsigned COUT_CAP  = (MAX_CH_OUT < CH_CAP) ? MAX_CH_OUT : CH_CAP;
    localparam int unsigned KW        = (KERNEL > 1) ? $clog2(KERNEL) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP1,
        ST_SETUP2,
        ST_SETUP3,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // configuration registers
    logic [5:0]              map_width_reg;
    logic [5:0]              map_height_reg;
    logic [4:0]              channels_in_reg;
    logic [4:0]              channels_out_reg;
    logic [2:0]              step_size_reg;
    logic [2:0]              border_pad_reg;
    logic signed [ACC_W-1:0] act_low_reg;
    logic signed [ACC_W-1:0] act_high_reg;

    // sizes clipped into their legal ranges
    logic [5:0] w_eff;
    logic [5:0] h_eff;
    logic [5:0] cin_eff;
    logic [5:0] cout_eff;
    logic [2:0] step_eff;

    // sequencer
    state_t                  state_reg, state_next;
    logic [PIX_W-1:0]        prow_reg, prow_next;
    logic [PIX_W-1:0]        pcol_reg, pcol_next;
    logic signed [Y_W-1:0]   row0_reg, row0_next;
    logic signed [Y_W-1:0]   col0_reg, col0_next;
    logic [11:0]             rowstep_reg, rowstep_next;
    logic signed [17:0]      base_reg, base_next;
    logic signed [MI_W-1:0]  start_reg, start_next;
    logic signed [MI_W-1:0]  row_start_reg, row_start_next;
    logic signed [MI_W-1:0]  mi_reg, mi_next;
    logic [WI_W-1:0]         wi_reg, wi_next;
    logic signed [Y_W-1:0]   y_reg, y_next;
    logic signed [Y_W-1:0]   x_reg, x_next;
    logic [4:0]              ci_reg, ci_next;
    logic [KW-1:0]           kx_reg, kx_next;
    logic [KW-1:0]           ky_reg, ky_next;
    logic [CH_W-1:0]         oc_reg, oc_next;

    logic [7:0]              row_prod;
    logic [7:0]              col_prod;
    logic signed [24:0]      start_full;
    logic signed [MI_W-1:0]  row_next_start;
    logic                    ci_end;
    logic                    kx_end;
    logic                    ky_end;
    logic                    ch_last;
    logic                    in_range;

    issue_t  issue;
    load_t   load;
    status_t status;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg    <= 6'd32;
            map_height_reg   <= 6'd32;
            channels_in_reg  <= 5'd16;
            channels_out_reg <= 5'd16;
            step_size_reg    <= 3'd1;
            border_pad_reg   <= 3'd0;
            act_low_reg      <= '0;
            act_high_reg     <= {1'b0, {(ACC_W-1){1'b1}}};
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MAP_WIDTH:    map_width_reg    <= cfg_data[5:0];
                REG_MAP_HEIGHT:   map_height_reg   <= cfg_data[5:0];
                REG_CHANNELS_IN:  channels_in_reg  <= cfg_data[4:0];
                REG_CHANNELS_OUT: channels_out_reg <= cfg_data[4:0];
                REG_STEP_SIZE:    step_size_reg    <= cfg_data[2:0];
                REG_BORDER_PAD:   border_pad_reg   <= cfg_data[2:0];
                REG_ACT_LOW:      act_low_reg      <= cfg_data;
                REG_ACT_HIGH:     act_high_reg     <= cfg_data;
                default:          act_high_reg     <= act_high_reg;
            endcase
        end
    end

    // clipped sizes
    always_comb
    begin
        w_eff    = sat_dim(map_width_reg, MAX_WIDTH);
        h_eff    = sat_dim(map_height_reg, MAX_HEIGHT);
        cin_eff  = sat_dim({1'b0, channels_in_reg}, MAX_CH_IN);
        cout_eff = sat_dim({1'b0, channels_out_reg}, COUT_CAP);
        step_eff = (step_size_reg == 3'd0) ? 3'd1 : step_size_reg;
    end

    // loop ends and tap range check
    always_comb
    begin
        ci_end   = ({1'b0, ci_reg} == (cin_eff - 6'd1));
        kx_end   = (kx_reg == KW'(KERNEL - 1));
        ky_end   = (ky_reg == KW'(KERNEL - 1));
        ch_last  = ({2'b00, oc_reg} == (cout_eff - 6'd1));
        in_range = (y_reg >= 0) && (y_reg < $signed({4'b0000, h_eff}))
                && (x_reg >= 0) && (x_reg < $signed({4'b0000, w_eff}))
                && (mi_reg < $signed(MI_W'(MAP_DEPTH)))
                && (wi_reg < WI_W'(WGT_DEPTH));
    end

    // tap toward the datapath
    always_comb
    begin
        issue.valid    = (state_reg == ST_RUN);
        issue.ok       = in_range;
        issue.tap_last = ci_end && kx_end && ky_end;
        issue.ch       = oc_reg;
        issue.ch_last  = ch_last;
        issue.map_addr = mi_reg[ADDR_W-1:0];
        issue.wgt_addr = wi_reg[ADDR_W-1:0];
    end

    // load beats write the stores directly
    assign cmd.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        load.map_we = cmd.valid && cmd.ready && (cmd.command == CMD_LOAD_MAP)
                   && ({1'b0, cmd.store_addr} < (ADDR_W+1)'(MAP_DEPTH));
        load.wgt_we = cmd.valid && cmd.ready && (cmd.command == CMD_LOAD_WGT)
                   && ({1'b0, cmd.store_addr} < (ADDR_W+1)'(WGT_DEPTH));
        load.addr   = cmd.store_addr;
        load.data   = cmd.load_value;
    end

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        prow_next      = prow_reg;
        pcol_next      = pcol_reg;
        row0_next      = row0_reg;
        col0_next      = col0_reg;
        rowstep_next   = rowstep_reg;
        base_next      = base_reg;
        start_next     = start_reg;
        row_start_next = row_start_reg;
        mi_next        = mi_reg;
        wi_next        = wi_reg;
        y_next         = y_reg;
        x_next         = x_reg;
        ci_next        = ci_reg;
        kx_next        = kx_reg;
        ky_next        = ky_reg;
        oc_next        = oc_reg;

        row_prod       = prow_reg * step_eff;
        col_prod       = pcol_reg * step_eff;
        start_full     = base_reg * $signed({1'b0, cin_eff});
        row_next_start = row_start_reg + $signed({10'b0, rowstep_reg});

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid && (cmd.command == CMD_COMPUTE))
                begin
                    prow_next  = cmd.pixel_row;
                    pcol_next  = cmd.pixel_col;
                    state_next = ST_SETUP1;
                end
            end
            // window origin and row pitch
            ST_SETUP1:
            begin
                row0_next    = $signed({2'b00, row_prod}) - $signed({7'b0, border_pad_reg});
                col0_next    = $signed({2'b00, col_prod}) - $signed({7'b0, border_pad_reg});
                rowstep_next = w_eff * cin_eff;
                state_next   = ST_SETUP2;
            end
            ST_SETUP2:
            begin
                base_next  = row0_reg * $signed({1'b0, w_eff}) + col0_reg;
                state_next = ST_SETUP3;
            end
            // first map index of the window, loop counters cleared
            ST_SETUP3:
            begin
                start_next     = start_full[MI_W-1:0];
                row_start_next = start_full[MI_W-1:0];
                mi_next        = start_full[MI_W-1:0];
                wi_next        = '0;
                y_next         = row0_reg;
                x_next         = col0_reg;
                ci_next        = '0;
                kx_next        = '0;
                ky_next        = '0;
                oc_next        = '0;
                state_next     = ST_RUN;
            end
            // one tap per cycle while the pipeline advances; a window row is contiguous in the map
            ST_RUN:
            begin
                if (status.adv)
                begin
                    wi_next = wi_reg + 1'b1;
                    mi_next = mi_reg + 1'b1;
                    if (!ci_end)
                    begin
                        ci_next = ci_reg + 1'b1;
                    end
                    else
                    begin
                        ci_next = '0;
                        if (!kx_end)
                        begin
                            kx_next = kx_reg + 1'b1;
                            x_next  = x_reg + 10'sd1;
                        end
                        else
                        begin
                            kx_next = '0;
                            x_next  = col0_reg;
                            if (!ky_end)
                            begin
                                ky_next        = ky_reg + 1'b1;
                                y_next         = y_reg + 10'sd1;
                                mi_next        = row_next_start;
                                row_start_next = row_next_start;
                            end
                            else
                            begin
                                ky_next        = '0;
                                y_next         = row0_reg;
                                mi_next        = start_reg;
                                row_start_next = start_reg;
                                if (ch_last)
                                begin
                                    state_next = ST_DRAIN;
                                end
                                else
                                begin
                                    oc_next = oc_reg + 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prow_reg      <= '0;
            pcol_reg      <= '0;
            row0_reg      <= '0;
            col0_reg      <= '0;
            rowstep_reg   <= '0;
            base_reg      <= '0;
            start_reg     <= '0;
            row_start_reg <= '0;
            mi_reg        <= '0;
            wi_reg        <= '0;
            y_reg         <= '0;
            x_reg         <= '0;
            ci_reg        <= '0;
            kx_reg        <= '0;
            ky_reg        <= '0;
            oc_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            prow_reg      <= prow_next;
            pcol_reg      <= pcol_next;
            row0_reg      <= row0_next;
            col0_reg      <= col0_next;
            rowstep_reg   <= rowstep_next;
            base_reg      <= base_next;
            start_reg     <= start_next;
            row_start_reg <= row_start_next;
            mi_reg        <= mi_next;
            wi_reg        <= wi_next;
            y_reg         <= y_next;
            x_reg         <= x_next;
            ci_reg        <= ci_next;
            kx_reg        <= kx_next;
            ky_reg        <= ky_next;
            oc_reg        <= oc_next;
        end
    end

    cnc_datapath #(
        .MAP_DEPTH (MAP_DEPTH),
        .WGT_DEPTH (WGT_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .issue    (issue),
        .load     (load),
        .act_low  (act_low_reg),
        .act_high (act_high_reg),
        .status   (status),
        .res      (res)
    );

    `CNC_ASSERT_NEXT(a_compute_blocks, cmd.valid && cmd.ready && (cmd.command == CMD_COMPUTE), !cmd.ready, "compute beat did not block the command channel")
    `CNC_ASSERT_SAME(a_idle_drained, state_reg == ST_IDLE, !status.busy, "idle with taps still in flight")
    `CNC_ASSERT_NEXT(a_channel_step, issue.valid && issue.tap_last && !issue.ch_last && status.adv, oc_reg == ($past(oc_reg) + 4'd1), "output channel did not advance")

endmodule

// ===== rtl/cnc_datapath.sv =====
// stores, shared multiply-accumulate, clamp and result register
`include "conv2d_nhwc_clamped_unit_defines.svh"

module cnc_datapath import cnc_pkg::*; #(
    parameter int unsigned MAP_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT * DEF_MAX_CH_IN,
    parameter int unsigned WGT_DEPTH = DEF_MAX_CH_OUT * DEF_KERNEL * DEF_KERNEL * DEF_MAX_CH_IN
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  issue_t                  issue,
    input  load_t                   load,
    input  logic signed [ACC_W-1:0] act_low,
    input  logic signed [ACC_W-1:0] act_high,
    output status_t                 status,
    cnc_res_if.source               res
);

    localparam int unsigned MAP_AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int unsigned WGT_AW = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;

    typedef struct packed {
        logic            ok;
        logic            tap_last;
        logic [CH_W-1:0] ch;
        logic            ch_last;
    } tag_t;

    logic signed [DATA_W-1:0] map_mem [0:MAP_DEPTH-1];
    logic signed [DATA_W-1:0] wgt_mem [0:WGT_DEPTH-1];

    logic                       adv;
    logic                       s1_valid_reg;
    tag_t                       s1_tag_reg;
    logic signed [DATA_W-1:0]   map_q_reg;
    logic signed [DATA_W-1:0]   wgt_q_reg;
    logic                       s2_valid_reg;
    tag_t                       s2_tag_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_sum;
    logic                       sum_valid_reg;
    logic signed [ACC_W-1:0]    sum_reg;
    logic [CH_W-1:0]            sum_ch_reg;
    logic                       sum_last_reg;
    logic                       out_valid_reg;
    logic signed [ACC_W-1:0]    out_value_reg;
    logic [CH_W-1:0]            out_ch_reg;
    logic                       out_last_reg;
    logic                       below_lo;
    logic                       above_hi;
    logic                       lo_over_hi;
    logic                       take_hi;
    logic signed [ACC_W-1:0]    clamped;

    // pipeline moves unless a held result blocks it
    assign adv         = !(out_valid_reg && !res.ready);
    assign status.adv  = adv;
    assign status.busy = s1_valid_reg | s2_valid_reg;

    // store writes from load beats
    always_ff @(posedge clk)
    begin
        if (load.map_we)
        begin
            map_mem[load.addr[MAP_AW-1:0]] <= load.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.wgt_we)
        begin
            wgt_mem[load.addr[WGT_AW-1:0]] <= load.data;
        end
    end

    // registered store reads for the issued tap
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            map_q_reg <= map_mem[issue.map_addr[MAP_AW-1:0]];
            wgt_q_reg <= wgt_mem[issue.wgt_addr[WGT_AW-1:0]];
        end
    end

    // tap tags following the reads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_tag_reg   <= '0;
            s2_valid_reg <= 1'b0;
            s2_tag_reg   <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg <= issue.valid;
            s1_tag_reg   <= '{ok: issue.ok, tap_last: issue.tap_last,
                              ch: issue.ch, ch_last: issue.ch_last};
            s2_valid_reg <= s1_valid_reg;
            s2_tag_reg   <= s1_tag_reg;
        end
    end

    // shared multiplier, taps outside the map give zero
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (s1_tag_reg.ok)
            begin
                prod_reg <= map_q_reg * wgt_q_reg;
            end
            else
            begin
                prod_reg <= '0;
            end
        end
    end

    assign acc_sum = acc_reg + prod_reg;

    // accumulator, hands the channel sum over on its last tap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            sum_valid_reg <= 1'b0;
            sum_reg       <= '0;
            sum_ch_reg    <= '0;
            sum_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            sum_valid_reg <= s2_valid_reg && s2_tag_reg.tap_last;
            if (s2_valid_reg)
            begin
                if (s2_tag_reg.tap_last)
                begin
                    acc_reg      <= '0;
                    sum_reg      <= acc_sum;
                    sum_ch_reg   <= s2_tag_reg.ch;
                    sum_last_reg <= s2_tag_reg.ch_last;
                end
                else
                begin
                    acc_reg <= acc_sum;
                end
            end
        end
    end

    // clamp: raise to act_low, then lower to act_high
    always_comb
    begin
        below_lo   = sum_reg < act_low;
        above_hi   = sum_reg > act_high;
        lo_over_hi = act_low > act_high;
        take_hi    = below_lo ? lo_over_hi : above_hi;
        if (take_hi)
        begin
            clamped = act_high;
        end
        else if (below_lo)
        begin
            clamped = act_low;
        end
        else
        begin
            clamped = sum_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_ch_reg    <= '0;
            out_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= sum_valid_reg;
            if (sum_valid_reg)
            begin
                out_value_reg <= clamped;
                out_ch_reg    <= sum_ch_reg;
                out_last_reg  <= sum_last_reg;
            end
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.out_value   = out_value_reg;
    assign res.out_channel = out_ch_reg;
    assign res.last        = out_last_reg;

    `CNC_ASSERT_NEXT(a_acc_cleared, adv && s2_valid_reg && s2_tag_reg.tap_last, acc_reg == '0, "accumulator not cleared after channel end")
    `CNC_ASSERT_SAME(a_result_from_sum, $rose(out_valid_reg), $past(sum_valid_reg), "result beat without a channel sum")
    `CNC_ASSERT_NEXT(a_sum_held, sum_valid_reg && !adv, sum_valid_reg && $stable(sum_reg), "channel sum lost during stall")

endmodule

// ===== test/conv_result_check.sv =====
// checker for the convolution unit: follows the channels, predicts each result beat and compares
module conv_result_check import cnc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    input  logic                     cmd_ready,
    input  logic [CMD_W-1:0]         command,
    input  logic [ADDR_W-1:0]        store_addr,
    input  logic signed [DATA_W-1:0] load_value,
    input  logic [PIX_W-1:0]         pixel_row,
    input  logic [PIX_W-1:0]         pixel_col,
    input  logic                     res_valid,
    input  logic                     res_ready,
    input  logic signed [ACC_W-1:0]  out_value,
    input  logic [CH_W-1:0]          out_channel,
    input  logic                     last,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [ACC_W-1:0]         cfg_data,
    output int unsigned              sums_outstanding,
    output int unsigned              mismatch_count
);

    localparam int KSZ       = DEF_KERNEL;
    localparam int MAP_WORDS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT * DEF_MAX_CH_IN;
    localparam int WGT_WORDS = DEF_MAX_CH_OUT * KSZ * KSZ * DEF_MAX_CH_IN;
    localparam int COUT_TOP  = (DEF_MAX_CH_OUT < CH_CAP) ? DEF_MAX_CH_OUT : CH_CAP;
    localparam int PRINT_CAP = 100;

    // one expected result beat
    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic [CH_W-1:0]         channel;
        logic                    last;
    } channel_sum_t;

    channel_sum_t sums_due [$];

    // local copies of the two stores
    logic signed [DATA_W-1:0] map_words [MAP_WORDS];
    logic signed [DATA_W-1:0] wgt_words [WGT_WORDS];

    // local copy of the register file
    logic [5:0]              reg_width;
    logic [5:0]              reg_height;
    logic [4:0]              reg_cin;
    logic [4:0]              reg_cout;
    logic [2:0]              reg_step;
    logic [2:0]              reg_pad;
    logic signed [ACC_W-1:0] reg_lo;
    logic signed [ACC_W-1:0] reg_hi;

    int unsigned  miss_total = 0;
    int unsigned  due_count  = 0;
    channel_sum_t head;

    assign sums_outstanding = due_count;
    assign mismatch_count   = miss_total;

    function automatic int clip(input int v, input int lo, input int hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        miss_total++;
        if (miss_total <= PRINT_CAP)
        begin
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        end
    endtask

    // window sums of one output pixel, one per output channel, clamped
    task automatic predict_pixel_sums(input logic [PIX_W-1:0] prow, input logic [PIX_W-1:0] pcol);
        int           w;
        int           h;
        int           cin;
        int           cout;
        int           step;
        int           pad;
        int           row0;
        int           col0;
        int           y;
        int           x;
        int           mi;
        int           wi;
        longint       acc;
        channel_sum_t beat;
        w    = clip(int'(reg_width), 1, DEF_MAX_WIDTH);
        h    = clip(int'(reg_height), 1, DEF_MAX_HEIGHT);
        cin  = clip(int'(reg_cin), 1, DEF_MAX_CH_IN);
        cout = clip(int'(reg_cout), 1, COUT_TOP);
        step = clip(int'(reg_step), 1, 7);
        pad  = int'(reg_pad);
        row0 = int'(prow) * step - pad;
        col0 = int'(pcol) * step - pad;
        for (int oc = 0; oc < cout; oc++)
        begin
            acc = 0;
            for (int ky = 0; ky < KSZ; ky++)
            begin
                y = row0 + ky;
                if (y < 0 || y >= h)
                begin
                    continue;
                end
                for (int kx = 0; kx < KSZ; kx++)
                begin
                    x = col0 + kx;
                    if (x < 0 || x >= w)
                    begin
                        continue;
                    end
                    for (int ci = 0; ci < cin; ci++)
                    begin
                        mi = (y * w + x) * cin + ci;
                        wi = oc * KSZ * KSZ * cin + (ky * KSZ + kx) * cin + ci;
                        if (mi < MAP_WORDS && wi < WGT_WORDS)
                        begin
                            acc += longint'(map_words[mi]) * longint'(wgt_words[wi]);
                        end
                    end
                end
            end
            // raise to the low bound first, then lower to the high bound
            if (acc < longint'(reg_lo))
            begin
                acc = longint'(reg_lo);
            end
            if (acc > longint'(reg_hi))
            begin
                acc = longint'(reg_hi);
            end
            beat.value   = ACC_W'(acc);
            beat.channel = CH_W'(oc);
            beat.last    = (oc == cout - 1);
            sums_due.push_back(beat);
        end
    endtask

    initial
    begin
        for (int i = 0; i < MAP_WORDS; i++)
        begin
            map_words[i] = '0;
        end
        for (int i = 0; i < WGT_WORDS; i++)
        begin
            wgt_words[i] = '0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_width  = 6'd32;
            reg_height = 6'd32;
            reg_cin    = 5'd16;
            reg_cout   = 5'd16;
            reg_step   = 3'd1;
            reg_pad    = 3'd0;
            reg_lo     = '0;
            reg_hi     = {1'b0, {(ACC_W-1){1'b1}}};
            sums_due.delete();
            due_count <= 0;
        end
        else
        begin
            // result beat against the oldest expectation
            if (res_valid && res_ready)
            begin
                if (sums_due.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected, channel", -1,
                                    longint'(out_channel));
                end
                else
                begin
                    head = sums_due.pop_front();
                    if (out_value !== head.value)
                    begin
                        report_mismatch($sformatf("out_value of channel %0d", head.channel),
                                        longint'(head.value), longint'(out_value));
                    end
                    if (out_channel !== head.channel)
                    begin
                        report_mismatch("out_channel", longint'(head.channel),
                                        longint'(out_channel));
                    end
                    if (last !== head.last)
                    begin
                        report_mismatch($sformatf("last of channel %0d", head.channel),
                                        longint'(head.last), longint'(last));
                    end
                end
            end

            // command beat: store write or pixel prediction
            if (cmd_valid && cmd_ready)
            begin
                if (command == CMD_LOAD_MAP)
                begin
                    if (int'(store_addr) < MAP_WORDS)
                    begin
                        map_words[store_addr] = load_value;
                    end
                end
                else if (command == CMD_LOAD_WGT)
                begin
                    if (int'(store_addr) < WGT_WORDS)
                    begin
                        wgt_words[store_addr] = load_value;
                    end
                end
                else if (command == CMD_COMPUTE)
                begin
                    predict_pixel_sums(pixel_row, pixel_col);
                end
            end

            // register write, kept at each register's width
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_MAP_WIDTH:    reg_width  = cfg_data[5:0];
                    REG_MAP_HEIGHT:   reg_height = cfg_data[5:0];
                    REG_CHANNELS_IN:  reg_cin    = cfg_data[4:0];
                    REG_CHANNELS_OUT: reg_cout   = cfg_data[4:0];
                    REG_STEP_SIZE:    reg_step   = cfg_data[2:0];
                    REG_BORDER_PAD:   reg_pad    = cfg_data[2:0];
                    REG_ACT_LOW:      reg_lo     = cfg_data;
                    REG_ACT_HIGH:     reg_hi     = cfg_data;
                    default:          ;
                endcase
            end

            due_count <= sums_due.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// testbench top for the convolution unit: clock, reset, stimulus, result ready and verdict
module tb_top;
    import cnc_pkg::*;

    localparam int               KSZ             = DEF_KERNEL;
    localparam int               MAP_WORDS       = DEF_MAX_WIDTH * DEF_MAX_HEIGHT * DEF_MAX_CH_IN;
    localparam int               WGT_WORDS       = DEF_MAX_CH_OUT * KSZ * KSZ * DEF_MAX_CH_IN;
    localparam logic [CMD_W-1:0] CMD_UNUSED      = 2'd3;
    localparam logic [ACC_W-1:0] ACT_MIN         = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [ACC_W-1:0] ACT_MAX         = {1'b0, {(ACC_W-1){1'b1}}};
    localparam int               RANDOM_ITEMS    = 260;
    localparam int               HOLD_OFF_CYCLES = 600;
    localparam int               SETTLE_CYCLES   = 16;
    localparam int               DRAIN_CYCLES    = 2400;
    localparam int unsigned      CYCLE_LIMIT     = 1000000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ACC_W-1:0]     cfg_data;

    int unsigned sums_outstanding;
    int unsigned mismatch_count;
    int unsigned cycle_count = 0;

    // stimulus shaping; the hold-off request is shared with the ready driver
    bit sender_sparse;
    bit hold_off_req;

    // sizes as the block sees them after saturation
    int eff_width;
    int eff_height;
    int eff_cin;
    int eff_cout;
    int eff_step;
    int eff_pad;

    cnc_cmd_if cmd_ch ();
    cnc_res_if res_ch ();

    conv2d_nhwc_clamped_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    conv_result_check result_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (cmd_ch.valid),
        .cmd_ready        (cmd_ch.ready),
        .command          (cmd_ch.command),
        .store_addr       (cmd_ch.store_addr),
        .load_value       (cmd_ch.load_value),
        .pixel_row        (cmd_ch.pixel_row),
        .pixel_col        (cmd_ch.pixel_col),
        .res_valid        (res_ch.valid),
        .res_ready        (res_ch.ready),
        .out_value        (res_ch.out_value),
        .out_channel      (res_ch.out_channel),
        .last             (res_ch.last),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .sums_outstanding (sums_outstanding),
        .mismatch_count   (mismatch_count)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // cycle counter and watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("FAIL");
        $finish;
    end

    function automatic int clip(input int v, input int lo, input int hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    // idle length: mostly none or short, a few long when not sparse
    function automatic int unsigned idle_cycles(input bit sparse);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (sparse)
        begin
            return (roll < 6) ? $urandom_range(1, 4) : 0;
        end
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // data word with the extremes turning up often
    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // one command beat, then an optional gap
    task automatic send_beat(input logic [CMD_W-1:0] code, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] word, input logic [PIX_W-1:0] row,
                             input logic [PIX_W-1:0] col);
        int unsigned gap;
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= code;
        cmd_ch.store_addr <= addr;
        cmd_ch.load_value <= word;
        cmd_ch.pixel_row  <= row;
        cmd_ch.pixel_col  <= col;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        gap = idle_cycles(sender_sparse);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load_word(input logic [CMD_W-1:0] code, input int addr,
                             input logic [DATA_W-1:0] word);
        send_beat(code, ADDR_W'(addr), word, PIX_W'($urandom), PIX_W'($urandom));
    endtask

    task automatic compute_at(input int row, input int col);
        send_beat(CMD_COMPUTE, ADDR_W'($urandom), DATA_W'($urandom), PIX_W'(row), PIX_W'(col));
    endtask

    // wait until every expected beat is in and the block has settled
    task automatic wait_for_idle();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (sums_outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all eight registers back to back while the block is idle
    task automatic apply_settings(input logic [ACC_W-1:0] width, input logic [ACC_W-1:0] height,
                                  input logic [ACC_W-1:0] cin, input logic [ACC_W-1:0] cout,
                                  input logic [ACC_W-1:0] step, input logic [ACC_W-1:0] pad,
                                  input logic [ACC_W-1:0] lo, input logic [ACC_W-1:0] hi);
        logic [ACC_W-1:0] plan [8];
        plan[REG_MAP_WIDTH]    = width;
        plan[REG_MAP_HEIGHT]   = height;
        plan[REG_CHANNELS_IN]  = cin;
        plan[REG_CHANNELS_OUT] = cout;
        plan[REG_STEP_SIZE]    = step;
        plan[REG_BORDER_PAD]   = pad;
        plan[REG_ACT_LOW]      = lo;
        plan[REG_ACT_HIGH]     = hi;
        wait_for_idle();
        for (int i = 0; i < 8; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= plan[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        eff_width  = clip(int'(width[5:0]), 1, DEF_MAX_WIDTH);
        eff_height = clip(int'(height[5:0]), 1, DEF_MAX_HEIGHT);
        eff_cin    = clip(int'(cin[4:0]), 1, DEF_MAX_CH_IN);
        eff_cout   = clip(int'(cout[4:0]), 1, DEF_MAX_CH_OUT);
        eff_step   = clip(int'(step[2:0]), 1, 7);
        eff_pad    = int'(pad[2:0]);
    endtask

    // random register set: mostly small sizes, sometimes large or out of range
    task automatic apply_random_settings();
        logic [ACC_W-1:0] width;
        logic [ACC_W-1:0] height;
        logic [ACC_W-1:0] cin;
        logic [ACC_W-1:0] cout;
        logic [ACC_W-1:0] step;
        logic [ACC_W-1:0] pad;
        logic [ACC_W-1:0] lo;
        logic [ACC_W-1:0] hi;
        int unsigned      roll;
        roll = $urandom_range(0, 11);
        if (roll < 2)
        begin
            width  = $urandom_range(16, 32);
            height = $urandom_range(16, 32);
            cin    = $urandom_range(8, 16);
            cout   = $urandom_range(8, 16);
        end
        else if (roll < 4)
        begin
            // raw values, out of range ones included
            width  = $urandom_range(0, 63);
            height = $urandom_range(0, 63);
            cin    = $urandom_range(0, 3);
            cout   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31);
        end
        else
        begin
            width  = $urandom_range(1, 8);
            height = $urandom_range(1, 8);
            cin    = $urandom_range(1, 4);
            cout   = $urandom_range(1, 6);
        end
        step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 3);
        pad  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
        // junk above the register width now and then
        if ($urandom_range(0, 3) == 0)
        begin
            width  = width | {ACC_W'($urandom), 6'd0};
            step   = step | {ACC_W'($urandom), 3'd0};
            cin    = cin | {ACC_W'($urandom), 5'd0};
        end
        case ($urandom_range(0, 5))
            0, 1:
            begin
                lo = ACT_MIN;
                hi = ACT_MAX;
            end
            2, 3:
            begin
                lo = ACC_W'(-longint'($urandom_range(0, 1 << 20)));
                hi = ACC_W'(longint'($urandom_range(0, 1 << 20)));
            end
            4:
            begin
                lo = ACC_W'({$urandom, $urandom});
                hi = ACC_W'({$urandom, $urandom});
            end
            default:
            begin
                // low bound above high bound
                lo = ACC_W'(longint'($urandom_range(1, 1 << 16)));
                hi = ACC_W'(-longint'($urandom_range(0, 1 << 16)));
            end
        endcase
        apply_settings(width, height, cin, cout, step, pad, lo, hi);
    endtask

    // result ready: random gaps, and one long hold-off on request
    initial
    begin : result_ready_driver
        int unsigned gap;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                gap = idle_cycles(1'b0);
                if (gap > 0)
                begin
                    res_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        int items;
        int n_loads;
        int max_row;
        int max_col;
        int row;
        int col;

        cmd_ch.valid      <= 1'b0;
        cmd_ch.command    <= CMD_LOAD_MAP;
        cmd_ch.store_addr <= '0;
        cmd_ch.load_value <= '0;
        cmd_ch.pixel_row  <= '0;
        cmd_ch.pixel_col  <= '0;
        cfg_wr_en         <= 1'b0;
        cfg_index         <= REG_MAP_WIDTH;
        cfg_data          <= '0;
        rst_n             <= 1'b0;
        sender_sparse      = 1'b1;
        hold_off_req       = 1'b0;
        eff_width          = DEF_MAX_WIDTH;
        eff_height         = DEF_MAX_HEIGHT;
        eff_cin            = DEF_MAX_CH_IN;
        eff_cout           = DEF_MAX_CH_OUT;
        eff_step           = 1;
        eff_pad            = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill both stores so that no read ever meets an unwritten word
        for (int a = 0; a < MAP_WORDS; a++)
        begin
            load_word(CMD_LOAD_MAP, a, rand_word());
        end
        for (int a = 0; a < WGT_WORDS; a++)
        begin
            load_word(CMD_LOAD_WGT, a, rand_word());
        end

        // directed: reset settings, corner pixels
        sender_sparse = 1'b0;
        compute_at(0, 0);
        compute_at(31, 31);

        // directed: small map, full clamp range, extreme words and addresses
        apply_settings(4, 3, 2, 3, 1, 1, ACT_MIN, ACT_MAX);
        load_word(CMD_LOAD_MAP, 0, {1'b1, {(DATA_W-1){1'b0}}});
        load_word(CMD_LOAD_MAP, 1, {1'b0, {(DATA_W-1){1'b1}}});
        load_word(CMD_LOAD_WGT, 0, {1'b1, {(DATA_W-1){1'b0}}});
        load_word(CMD_LOAD_WGT, 1, {1'b0, {(DATA_W-1){1'b1}}});
        load_word(CMD_LOAD_MAP, STORE_SPAN - 1, {1'b0, {(DATA_W-1){1'b1}}});
        load_word(CMD_LOAD_WGT, STORE_SPAN - 1, '1);
        load_word(CMD_UNUSED, 5, '1);
        compute_at(0, 0);
        compute_at(1, 1);
        compute_at(31, 0);
        compute_at(0, 31);

        // directed: every size register out of range
        apply_settings(63, 0, 31, 0, 0, 7, ACT_MIN, ACT_MAX);
        compute_at(0, 0);
        compute_at(3, 5);

        // directed: low bound above high bound
        apply_settings(3, 3, 1, 2, 1, 0, ACC_W'(1000), ACC_W'(-1000));
        compute_at(0, 0);

        // directed: largest sizes, largest stride and padding, narrow clamp
        apply_settings(32, 32, 16, 16, 7, 7, ACC_W'(-(64'sd1 << 20)), ACC_W'(64'sd1 << 20));
        compute_at(0, 0);
        compute_at(5, 5);
        compute_at(4, 4);

        // result side holds off while computes keep coming
        apply_settings(4, 4, 1, 4, 1, 1, ACT_MIN, ACT_MAX);
        sender_sparse = 1'b1;
        hold_off_req  = 1'b1;
        for (int i = 0; i < 10; i++)
        begin
            compute_at($urandom_range(0, 3), $urandom_range(0, 3));
        end

        // random: loads into the active region followed by computes, some noise
        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            apply_random_settings();
            sender_sparse = ($urandom_range(0, 2) == 0);
            max_row = clip((eff_height + 2 * eff_pad - KSZ) / eff_step, 0, 31);
            max_col = clip((eff_width + 2 * eff_pad - KSZ) / eff_step, 0, 31);
            repeat ($urandom_range(3, 7))
            begin
                n_loads = $urandom_range(0, 4);
                for (int i = 0; i < n_loads; i++)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        load_word(CMD_LOAD_MAP,
                                  $urandom_range(0, eff_width * eff_height * eff_cin - 1),
                                  rand_word());
                    end
                    else
                    begin
                        load_word(CMD_LOAD_WGT,
                                  $urandom_range(0, eff_cout * KSZ * KSZ * eff_cin - 1),
                                  rand_word());
                    end
                    items++;
                end
                repeat ($urandom_range(1, 2))
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        row = $urandom_range(0, 31);
                        col = $urandom_range(0, 31);
                    end
                    else
                    begin
                        row = $urandom_range(0, max_row);
                        col = $urandom_range(0, max_col);
                    end
                    compute_at(row, col);
                    items++;
                end
                // noise: unused code, ignored weight address, stray map word
                if ($urandom_range(0, 4) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: load_word(CMD_UNUSED, $urandom_range(0, STORE_SPAN - 1), rand_word());
                        1: load_word(CMD_LOAD_WGT, $urandom_range(WGT_WORDS, STORE_SPAN - 1),
                                     rand_word());
                        default:
                        begin
                            load_word(CMD_LOAD_MAP, $urandom_range(0, STORE_SPAN - 1),
                                      rand_word());
                            items++;
                        end
                    endcase
                end
            end
        end

        // drain and verdict
        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
